// ----- rtl/gls_pkg.sv -----
package gls_pkg;

  localparam int SENSOR_COUNT = 16;
  localparam int MAX_SEGMENTS = 4;

  localparam int IDX_W    = $clog2(SENSOR_COUNT);
  localparam int PC_W     = $clog2(SENSOR_COUNT + 1);
  localparam int ACTIVE_W = 5;
  localparam int SEG_W    = 3;
  localparam int MID_W    = 6;
  localparam int MR_W     = 5;
  localparam int FR_W     = 8;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int IN_W     = 16;
  localparam int OUT_W    = 16;

  typedef enum logic [2:0] {
    REG_BRANCH_LEFT    = 3'd0,
    REG_DEFAULT_MIDDLE = 3'd1,
    REG_MIN_RUN        = 3'd2,
    REG_OFF_FRAMES     = 3'd3,
    REG_ON_FRAMES      = 3'd4
  } reg_idx_t;

  localparam logic [MID_W-1:0] DEFAULT_MIDDLE_RST = MID_W'(17);
  localparam logic [MR_W-1:0]  MIN_RUN_RST        = MR_W'(2);
  localparam logic [FR_W-1:0]  OFF_FRAMES_RST     = FR_W'(5);
  localparam logic [FR_W-1:0]  ON_FRAMES_RST      = FR_W'(10);

endpackage

// ----- rtl/guide_line_segment_tracker.sv -----
// Guide-line segment tracker.
// A frame request on the in_ channel carries the sensor mask in in_tdata. For
// every frame one result request leaves on the out_ channel with the active
// sensor count, the number of qualifying segments, a single-segment flag, the
// doubled middle of the followed segment and the on-line status.
// Runs of active sensors at least min_run long count as segments. The first
// segment is followed, or the second one at a fork when branch_left is set.
// With no segment the last middle is repeated, or default_middle before any
// segment was seen. The on-line status changes after on_frames frames with
// segments or off_frames empty frames in a row.
// A frame passes an input register, then the segment scan, then the result
// register. One frame is accepted in every cycle unless the receiver stalls;
// the scan over the mask is a single combinational pass between those two
// registers, so the rate is one frame per cycle. A stalled receiver holds the
// result register; the input register still takes one more frame, after which
// in_tready drops until the result leaves. Reset returns all registers to
// their defaults and empties both stages. The user must write registers over
// the cfg_ port only while the block is idle; the block does not enforce it.
module guide_line_segment_tracker (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // sensor_mask[15:0]
  input  logic [gls_pkg::IN_W-1:0] in_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // active_count[4:0], segment_count[7:5], single_segment[8],
  // middle_pos[14:9], on_line[15]
  output logic [gls_pkg::OUT_W-1:0] out_tdata,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [gls_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [gls_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [gls_pkg::DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import gls_pkg::*;

  localparam int N = SENSOR_COUNT;

  logic                  branch_left_r;
  logic [MID_W-1:0]      default_middle_r;
  logic [MR_W-1:0]       min_run_r;
  logic [FR_W-1:0]       off_frames_r;
  logic [FR_W-1:0]       on_frames_r;

  logic                  s1_valid_r;
  logic [N-1:0]          s1_mask_r;
  logic                  out_valid_r;
  logic [OUT_W-1:0]      out_data_r;

  logic [MID_W-1:0]      last_middle_r;
  logic                  middle_seen_r;
  logic                  online_r;
  logic [FR_W-1:0]       frame_cnt_r;

  logic                  in_accept;
  logic                  advance;
  logic                  cfg_write;
  reg_idx_t              cfg_idx;

  logic [N-1:0]          run_end;
  logic [N-1:0]          run_start;
  logic [N-1:0]          seg_ok;
  logic [N-1:0]          seg_second;
  logic [N-1:0]          seg_pick;
  logic [N-1:0]          shifted;
  logic [N-1:0]          inv_top;
  logic [MR_W-1:0]       mr_eff;
  logic [MR_W-1:0]       top_sh;
  logic                  mr_fits;
  logic [PC_W-1:0]       active_pc;
  logic [PC_W-1:0]       seg_pc;
  logic [SEG_W-1:0]      seg_count;
  logic [IDX_W-1:0]      end_idx;
  logic [IDX_W-1:0]      head_idx;
  logic [MID_W-1:0]      seg_middle;
  logic [MID_W-1:0]      middle;
  logic                  online_nxt;
  logic [FR_W-1:0]       frame_cnt_nxt;
  logic [FR_W-1:0]       frame_cnt_inc;
  logic [OUT_W-1:0]      out_data_nxt;

  assign in_accept  = in_tvalid && in_tready;
  assign advance    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[ADDR_W-1:2]);

  always_comb begin
    case (cfg_idx)
      REG_BRANCH_LEFT:    cfg_prdata = DATA_W'(branch_left_r);
      REG_DEFAULT_MIDDLE: cfg_prdata = DATA_W'(default_middle_r);
      REG_MIN_RUN:        cfg_prdata = DATA_W'(min_run_r);
      REG_OFF_FRAMES:     cfg_prdata = DATA_W'(off_frames_r);
      REG_ON_FRAMES:      cfg_prdata = DATA_W'(on_frames_r);
      default:            cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      branch_left_r    <= 1'b0;
      default_middle_r <= DEFAULT_MIDDLE_RST;
      min_run_r        <= MIN_RUN_RST;
      off_frames_r     <= OFF_FRAMES_RST;
      on_frames_r      <= ON_FRAMES_RST;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_BRANCH_LEFT:    branch_left_r    <= cfg_pwdata[0];
        REG_DEFAULT_MIDDLE: default_middle_r <= cfg_pwdata[MID_W-1:0];
        REG_MIN_RUN:        min_run_r        <= cfg_pwdata[MR_W-1:0];
        REG_OFF_FRAMES:     off_frames_r     <= cfg_pwdata[FR_W-1:0];
        REG_ON_FRAMES:      on_frames_r      <= cfg_pwdata[FR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // A run ending at sensor i qualifies when the min_run sensors up to i are
  // all active; moving sensor i to the top bit makes that a test of top bits.
  always_comb begin
    mr_eff    = (min_run_r == '0) ? MR_W'(1) : min_run_r;
    mr_fits   = (mr_eff <= MR_W'(N));
    top_sh    = MR_W'(N) - mr_eff;
    run_end   = s1_mask_r & ~({1'b0, s1_mask_r[N-1:1]});
    run_start = s1_mask_r & ~({s1_mask_r[N-2:0], 1'b0});
    seg_ok    = '0;
    shifted   = '0;
    inv_top   = '0;
    for (int i = 0; i < N; i++) begin
      shifted   = s1_mask_r << (N - 1 - i);
      inv_top   = (~shifted) >> top_sh;
      seg_ok[i] = run_end[i] && mr_fits && (inv_top == '0);
    end
  end

  always_comb begin
    active_pc = '0;
    seg_pc    = '0;
    for (int i = 0; i < N; i++) begin
      active_pc = active_pc + PC_W'(s1_mask_r[i]);
      seg_pc    = seg_pc + PC_W'(seg_ok[i]);
    end
    if (seg_pc > PC_W'(MAX_SEGMENTS)) begin
      seg_count = SEG_W'(MAX_SEGMENTS);
    end else begin
      seg_count = SEG_W'(seg_pc);
    end
  end

  always_comb begin
    seg_second = seg_ok & (seg_ok - N'(1));
    seg_pick   = (branch_left_r && seg_count >= SEG_W'(2)) ? seg_second : seg_ok;
    end_idx    = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (seg_pick[i]) begin
        end_idx = IDX_W'(i);
      end
    end
    head_idx = '0;
    for (int i = 0; i < N; i++) begin
      if (run_start[i] && (IDX_W'(i) <= end_idx)) begin
        head_idx = IDX_W'(i);
      end
    end
    seg_middle = MID_W'(head_idx) + MID_W'(end_idx) + MID_W'(2);
    if (seg_count == '0) begin
      middle = middle_seen_r ? last_middle_r : default_middle_r;
    end else begin
      middle = seg_middle;
    end
  end

  always_comb begin
    frame_cnt_inc = frame_cnt_r + FR_W'(1);
    online_nxt    = online_r;
    frame_cnt_nxt = '0;
    if (online_r) begin
      if (seg_count == '0) begin
        if (frame_cnt_inc >= off_frames_r) begin
          online_nxt = 1'b0;
        end else begin
          frame_cnt_nxt = frame_cnt_inc;
        end
      end
    end else begin
      if (seg_count != '0) begin
        if (frame_cnt_inc >= on_frames_r) begin
          online_nxt = 1'b1;
        end else begin
          frame_cnt_nxt = frame_cnt_inc;
        end
      end
    end
    out_data_nxt = {online_nxt, middle, (seg_count == SEG_W'(1)), seg_count,
                    ACTIVE_W'(active_pc)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      last_middle_r <= DEFAULT_MIDDLE_RST;
      middle_seen_r <= 1'b0;
      online_r      <= 1'b0;
      frame_cnt_r   <= '0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        online_r    <= online_nxt;
        frame_cnt_r <= frame_cnt_nxt;
        if (seg_count != '0) begin
          last_middle_r <= seg_middle;
          middle_seen_r <= 1'b1;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_mask_r <= in_tdata[N-1:0];
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_online_moves_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(online_r))
    else $error("line status changed without a frame");

  a_single_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[8] == (out_data_r[7:5] == SEG_W'(1))))
    else $error("single segment flag disagrees with segment count");

  a_seg_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[7:5] <= SEG_W'(MAX_SEGMENTS)))
    else $error("segment count above limit");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with an empty result register");

  a_result_follows_advance: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("frame left the input register without a result");
`endif

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import gls_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam logic [ADDR_W-1:0] SPARE_ADDR = 5'd20;

  typedef struct packed {
    logic       on_line;
    logic [5:0] middle_pos;
    logic       single_segment;
    logic [2:0] segment_count;
    logic [4:0] active_count;
  } frame_result_t;

  typedef enum int {BURST_EMPTY, BURST_RUNS, BURST_NOISE} burst_kind_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [IN_W-1:0]     in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_W-1:0]    out_tdata;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0]   cfg_paddr = '0;
  logic [DATA_W-1:0]   cfg_pwdata = '0;
  logic [DATA_W-1:0]   cfg_prdata;
  logic                cfg_pready;

  logic [IN_W-1:0] frames_to_send[$];
  frame_result_t   results_due[$];

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int errors = 0;
  int cycle_count = 0;
  int src_idle_tab[4] = '{0, 53, 0, 38};
  int snk_stall_tab[4] = '{0, 0, 53, 38};

  logic             shadow_branch = 1'b0;
  logic [MID_W-1:0] shadow_default_mid = DEFAULT_MIDDLE_RST;
  logic [MR_W-1:0]  shadow_min_run = MIN_RUN_RST;
  logic [FR_W-1:0]  shadow_off = OFF_FRAMES_RST;
  logic [FR_W-1:0]  shadow_on = ON_FRAMES_RST;

  logic [MID_W-1:0] last_mid = DEFAULT_MIDDLE_RST;
  logic             mid_seen = 1'b0;
  logic             online = 1'b0;
  logic [FR_W-1:0]  frame_streak = '0;

  guide_line_segment_tracker uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  function automatic frame_result_t track_frame(input logic [IN_W-1:0] mask);
    int segs;
    int active;
    int head;
    int mid;
    int mids[MAX_SEGMENTS];
    bit in_run;
    bit scanning;
    frame_result_t r;
    segs = 0;
    active = 0;
    head = 0;
    in_run = 1'b0;
    scanning = 1'b1;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      if (mask[i]) begin
        active++;
        if (!in_run) begin
          in_run = 1'b1;
          head = i + 1;
        end
      end else if (in_run) begin
        in_run = 1'b0;
        if (scanning && (i + 1 - head) >= int'(shadow_min_run) && segs < MAX_SEGMENTS) begin
          mids[segs] = head + i;
          segs++;
          if (segs >= MAX_SEGMENTS) scanning = 1'b0;
        end
      end
    end
    if (in_run && scanning && (SENSOR_COUNT + 1 - head) >= int'(shadow_min_run)
        && segs < MAX_SEGMENTS) begin
      mids[segs] = head + SENSOR_COUNT;
      segs++;
    end

    if (segs == 0) begin
      mid = mid_seen ? int'(last_mid) : int'(shadow_default_mid);
    end else begin
      mid = (segs >= 2 && shadow_branch) ? mids[1] : mids[0];
      last_mid = MID_W'(mid);
      mid_seen = 1'b1;
    end

    if (online) begin
      if (segs == 0) begin
        frame_streak = frame_streak + 8'd1;
        if (frame_streak >= shadow_off) begin
          online = 1'b0;
          frame_streak = '0;
        end
      end else begin
        frame_streak = '0;
      end
    end else begin
      if (segs != 0) begin
        frame_streak = frame_streak + 8'd1;
        if (frame_streak >= shadow_on) begin
          online = 1'b1;
          frame_streak = '0;
        end
      end else begin
        frame_streak = '0;
      end
    end

    r.active_count = 5'(active);
    r.segment_count = 3'(segs);
    r.single_segment = (segs == 1);
    r.middle_pos = MID_W'(mid);
    r.on_line = online;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) results_due.push_back(track_frame(in_tdata));
      if (!in_tvalid || in_tready) begin
        if (frames_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_tdata <= frames_to_send.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    frame_result_t got;
    frame_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, out_tdata);
        errors++;
      end else begin
        want = results_due.pop_front();
        check_field("active_count", want.active_count, got.active_count);
        check_field("segment_count", want.segment_count, got.segment_count);
        check_field("single_segment", want.single_segment, got.single_segment);
        check_field("middle_pos", want.middle_pos, got.middle_pos);
        check_field("on_line", want.on_line, got.on_line);
      end
    end
    out_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic cfg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (addr[4:2])
      REG_BRANCH_LEFT:    shadow_branch = val[0];
      REG_DEFAULT_MIDDLE: shadow_default_mid = val[MID_W-1:0];
      REG_MIN_RUN:        shadow_min_run = val[MR_W-1:0];
      REG_OFF_FRAMES:     shadow_off = val[FR_W-1:0];
      REG_ON_FRAMES:      shadow_on = val[FR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int br, input int dm, input int mr, input int off, input int on);
    cfg_write({REG_BRANCH_LEFT, 2'b00}, br);
    cfg_write({REG_DEFAULT_MIDDLE, 2'b00}, dm);
    cfg_write({REG_MIN_RUN, 2'b00}, mr);
    cfg_write({REG_OFF_FRAMES, 2'b00}, off);
    cfg_write({REG_ON_FRAMES, 2'b00}, on);
  endtask

  task automatic wait_drain();
    while (frames_to_send.size() != 0 || in_tvalid || results_due.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic push_bursts(input int n);
    burst_kind_t kind;
    int len;
    logic [IN_W-1:0] r;
    logic [IN_W-1:0] m;
    while (n > 0) begin
      kind = burst_kind_t'($urandom_range(2));
      len = ($urandom_range(9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
      if (len > n) len = n;
      repeat (len) begin
        r = $urandom;
        case (kind)
          BURST_EMPTY: m = $urandom_range(1) ? '0 : (r & IN_W'($urandom) & 16'h5555);
          BURST_RUNS:  m = r | (r << 1);
          default:     m = r;
        endcase
        frames_to_send.push_back(m);
      end
      n -= len;
    end
  endtask

  task automatic run_phase(input int idx, input int n);
    src_idle_pct = src_idle_tab[idx % 4];
    snk_stall_pct = snk_stall_tab[idx % 4];
    push_bursts(n / 2);
    wait_drain();
    push_bursts(n - n / 2);
    wait_drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    src_idle_pct = 38;
    snk_stall_pct = 38;
    frames_to_send = '{16'h0000, 16'h0001};
    wait_drain();
    cfg_write({REG_DEFAULT_MIDDLE, 2'b00}, 63);
    frames_to_send = '{16'h0000, 16'h0003, 16'h0001, 16'hC000, 16'h8000, 16'hFFFF,
                       16'h6DB6, 16'h3333, 16'h0660, 16'hAAAA, 16'h5555, 16'h0000};
    wait_drain();

    set_config(1, 40, 1, 1, 1);
    cfg_write(SPARE_ADDR, 32'hFFFF_FFFF);
    frames_to_send = '{16'h0005, 16'h0000, 16'h0101, 16'h0000, 16'h1248,
                       16'hFFFF, 16'h0000, 16'h8001};
    wait_drain();

    set_config(0, 0, 1, 1, 1);
    run_phase(0, 250);
    set_config(1, 63, 16, 255, 255);
    run_phase(1, 700);
    set_config(1, 32, 0, 0, 0);
    run_phase(2, 250);
    set_config(0, 17, 31, 3, 4);
    run_phase(3, 250);
    for (int p = 4; p < 8; p++) begin
      set_config($urandom_range(1), $urandom_range(63), $urandom_range(1, 6),
                 $urandom_range(1, 12), $urandom_range(1, 12));
      run_phase(p, 250);
    end

    repeat (10) @(posedge clk);
    if (results_due.size() != 0) begin
      $display("%0t: results missing: expected %0d more, actual 0", $time, results_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
